@@ src/mrfd_pkg.sv @@
`timescale 1ns / 1ps

package mrfd_pkg;

  localparam int FRAME_BYTES = 7;
  localparam int VOLT_W = 20;
  localparam int CURR_W = 23;
  localparam int POWR_W = 16;
  localparam int ENRG_W = 24;
  localparam int CNT_W = 5;
  localparam int CFG_DATA_W = 23;
  localparam int CFG_INDEX_W = 8;

  localparam logic [4:0] HEADER_PREFIX = 5'b10100;
  localparam logic [CNT_W-1:0] COUNT_MAX = 5'd31;

  localparam logic [2:0] Q_VOLTAGE = 3'd0;
  localparam logic [2:0] Q_CURRENT = 3'd1;
  localparam logic [2:0] Q_POWER = 3'd2;
  localparam logic [2:0] Q_ENERGY = 3'd3;
  localparam logic [2:0] Q_ADDRESS = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_HEADER = 2'd1;
  localparam logic [1:0] ST_CHECKSUM = 2'd2;
  localparam logic [1:0] ST_SHORT = 2'd3;

  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TIMEOUT = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_VOLTAGE_LIMIT = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CURRENT_LIMIT = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_POWER_LIMIT = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ERROR_LIMIT = 8'd3;

  localparam logic [VOLT_W-1:0] VOLTAGE_LIMIT_RESET = 20'd4000;
  localparam logic [CURR_W-1:0] CURRENT_LIMIT_RESET = 23'd10000;
  localparam logic [POWR_W-1:0] POWER_LIMIT_RESET = 16'd25000;
  localparam logic [CNT_W-1:0] ERROR_LIMIT_RESET = 5'd20;

  typedef struct packed {
    logic [2:0] which;
    logic [1:0] status;
    logic [23:0] decoded;
    logic [23:0] held;
    logic [CNT_W-1:0] error_count;
    logic reinit_needed;
    logic link_ready;
  } result_t;

endpackage

@@ src/meter_response_frame_decoder.sv @@
`timescale 1ns / 1ps

// A frame-ending request's result is registered on acceptance (skid entry if output held).
// One request per cycle while in_ready is high; per-byte work sits before the result register.
// A two-entry output buffer keeps accepting while one result waits to be taken.
// Reset (synchronous, active high) clears the frame state, held values, error count,
// link flag and output buffer, and loads the limit registers with their defaults.
module meter_response_frame_decoder (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic func,
  input  logic [2:0] quantity,
  input  logic [7:0] rx_byte,
  output logic out_valid,
  input  logic out_ready,
  output logic [2:0] which,
  output logic [1:0] status,
  output logic [23:0] decoded,
  output logic [23:0] held,
  output logic [4:0] error_count,
  output logic reinit_needed,
  output logic link_ready,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [mrfd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mrfd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mrfd_pkg::*;

  logic [VOLT_W-1:0] voltage_limit;
  logic [CURR_W-1:0] current_limit;
  logic [POWR_W-1:0] power_limit;
  logic [CNT_W-1:0] error_limit;

  logic [2:0] byte_index;
  logic [7:0] running_sum;
  logic header_good;
  logic [23:0] payload_bytes;
  logic [VOLT_W-1:0] held_voltage;
  logic [CURR_W-1:0] held_current;
  logic [POWR_W-1:0] held_power;
  logic [ENRG_W-1:0] held_energy;
  logic [CNT_W-1:0] failure_count;
  logic ready_flag;

  logic [2:0] byte_index_next;
  logic [7:0] running_sum_next;
  logic header_good_next;
  logic [23:0] payload_bytes_next;
  logic [VOLT_W-1:0] held_voltage_next;
  logic [CURR_W-1:0] held_current_next;
  logic [POWR_W-1:0] held_power_next;
  logic [ENRG_W-1:0] held_energy_next;
  logic [CNT_W-1:0] failure_count_next;
  logic ready_flag_next;

  result_t out_data;
  result_t skid_data;
  logic skid_valid;
  result_t res;

  logic in_fire;
  logic finish_now;
  logic [1:0] fin_status;
  logic ok;
  logic [15:0] hi;
  logic [7:0] lo;
  logic [VOLT_W-1:0] dec_voltage;
  logic [CURR_W-1:0] dec_current;
  logic [23:0] dec;
  logic [23:0] held_out;

  assign cfg_ready = 1'b1;
  assign in_ready = !skid_valid;
  assign in_fire = in_valid && in_ready;

  assign hi = payload_bytes[23:8];
  assign lo = payload_bytes[7:0];
  assign dec_voltage = VOLT_W'(hi) * VOLT_W'(10) + VOLT_W'(lo);
  assign dec_current = CURR_W'(hi) * CURR_W'(100) + CURR_W'(lo);

  always_comb begin
    byte_index_next = byte_index;
    running_sum_next = running_sum;
    header_good_next = header_good;
    payload_bytes_next = payload_bytes;
    held_voltage_next = held_voltage;
    held_current_next = held_current;
    held_power_next = held_power;
    held_energy_next = held_energy;
    failure_count_next = failure_count;
    ready_flag_next = ready_flag;
    finish_now = 1'b0;
    fin_status = ST_OK;
    dec = '0;
    held_out = '0;

    if (func == FUNC_TIMEOUT) begin
      finish_now = 1'b1;
      fin_status = ST_SHORT;
    end else if (byte_index == 3'd0) begin
      header_good_next = (rx_byte == {HEADER_PREFIX, quantity});
      running_sum_next = rx_byte;
      payload_bytes_next = '0;
      byte_index_next = 3'd1;
    end else if (byte_index >= 3'(FRAME_BYTES - 1)) begin
      finish_now = 1'b1;
      if (!header_good) begin
        fin_status = ST_HEADER;
      end else if (rx_byte != running_sum) begin
        fin_status = ST_CHECKSUM;
      end
    end else begin
      if (byte_index <= 3'd3) begin
        payload_bytes_next = {payload_bytes[15:0], rx_byte};
      end
      running_sum_next = running_sum + rx_byte;
      byte_index_next = byte_index + 3'd1;
    end

    ok = (fin_status == ST_OK);

    if (finish_now) begin
      case (quantity)
        Q_VOLTAGE: begin
          if (ok) begin
            dec = 24'(dec_voltage);
          end
          if (!ok || dec_voltage == '0) begin
            if (failure_count < COUNT_MAX) begin
              failure_count_next = failure_count + 5'd1;
            end
          end else if (dec_voltage <= voltage_limit) begin
            held_voltage_next = dec_voltage;
          end
          held_out = 24'(held_voltage_next);
        end
        Q_CURRENT: begin
          if (ok) begin
            dec = 24'(dec_current);
            if (dec_current != '0 && dec_current <= current_limit) begin
              held_current_next = dec_current;
            end
          end
          held_out = 24'(held_current_next);
        end
        Q_POWER: begin
          if (ok) begin
            dec = 24'(hi);
            if (hi != '0 && hi <= power_limit) begin
              held_power_next = hi;
            end
          end
          held_out = 24'(held_power_next);
        end
        Q_ENERGY: begin
          if (ok) begin
            dec = payload_bytes;
            if (payload_bytes != '0) begin
              held_energy_next = payload_bytes;
            end
          end
          held_out = held_energy_next;
        end
        Q_ADDRESS: begin
          if (ok) begin
            ready_flag_next = 1'b1;
            failure_count_next = '0;
          end
        end
        default: begin
        end
      endcase
      byte_index_next = '0;
      running_sum_next = '0;
      header_good_next = 1'b0;
      payload_bytes_next = '0;
    end

    res.which = quantity;
    res.status = fin_status;
    res.decoded = dec;
    res.held = held_out;
    res.error_count = failure_count_next;
    res.reinit_needed = (failure_count_next >= error_limit);
    res.link_ready = ready_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      voltage_limit <= VOLTAGE_LIMIT_RESET;
      current_limit <= CURRENT_LIMIT_RESET;
      power_limit <= POWER_LIMIT_RESET;
      error_limit <= ERROR_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_VOLTAGE_LIMIT: voltage_limit <= cfg_data[VOLT_W-1:0];
        REG_CURRENT_LIMIT: current_limit <= cfg_data[CURR_W-1:0];
        REG_POWER_LIMIT: power_limit <= cfg_data[POWR_W-1:0];
        REG_ERROR_LIMIT: error_limit <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= '0;
      running_sum <= '0;
      header_good <= 1'b0;
      payload_bytes <= '0;
      held_voltage <= '0;
      held_current <= '0;
      held_power <= '0;
      held_energy <= '0;
      failure_count <= '0;
      ready_flag <= 1'b0;
    end else if (in_fire) begin
      byte_index <= byte_index_next;
      running_sum <= running_sum_next;
      header_good <= header_good_next;
      payload_bytes <= payload_bytes_next;
      held_voltage <= held_voltage_next;
      held_current <= held_current_next;
      held_power <= held_power_next;
      held_energy <= held_energy_next;
      failure_count <= failure_count_next;
      ready_flag <= ready_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        out_data <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (in_fire && finish_now) begin
      if (!out_valid || out_ready) begin
        out_data <= res;
        out_valid <= 1'b1;
      end else begin
        skid_data <= res;
        skid_valid <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign which = out_data.which;
  assign status = out_data.status;
  assign decoded = out_data.decoded;
  assign held = out_data.held;
  assign error_count = out_data.error_count;
  assign reinit_needed = out_data.reinit_needed;
  assign link_ready = out_data.link_ready;

endmodule

@@ bench/meter_response_frame_decoder_test.sv @@
`timescale 1ns / 1ps

module meter_response_frame_decoder_test;
  import mrfd_pkg::*;

  typedef enum {FLAW_NONE, FLAW_HEADER, FLAW_CHECKSUM, FLAW_BOTH, FLAW_CUT} frame_flaw_t;

  localparam int LAST_PAYLOAD_POS = 3;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic func = FUNC_BYTE;
  logic [2:0] quantity = Q_VOLTAGE;
  logic [7:0] rx_byte = 8'h00;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] which;
  logic [1:0] status;
  logic [23:0] decoded;
  logic [23:0] held;
  logic [4:0] error_count;
  logic reinit_needed;
  logic link_ready;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_VOLTAGE_LIMIT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [2:0] frame_pos;
  logic [7:0] frame_sum;
  logic header_ok;
  logic [23:0] frame_payload;
  logic [VOLT_W-1:0] voltage_held;
  logic [CURR_W-1:0] current_held;
  logic [POWR_W-1:0] power_held;
  logic [ENRG_W-1:0] energy_held;
  logic [CNT_W-1:0] failures_seen;
  logic link_up;
  logic [VOLT_W-1:0] voltage_limit;
  logic [CURR_W-1:0] current_limit;
  logic [POWR_W-1:0] power_limit;
  logic [CNT_W-1:0] error_limit;

  result_t expected_results[$];
  int mismatch_count = 0;
  int requests_sent = 0;
  logic sender_steady = 1'b0;
  logic receiver_steady = 1'b0;
  int receiver_hold = 0;

  meter_response_frame_decoder dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .func(func),
    .quantity(quantity),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .which(which),
    .status(status),
    .decoded(decoded),
    .held(held),
    .error_count(error_count),
    .reinit_needed(reinit_needed),
    .link_ready(link_ready),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void clear_frame_state();
    frame_pos = '0;
    frame_sum = '0;
    header_ok = 1'b0;
    frame_payload = '0;
  endfunction

  function automatic void reset_meter_model();
    clear_frame_state();
    voltage_held = '0;
    current_held = '0;
    power_held = '0;
    energy_held = '0;
    failures_seen = '0;
    link_up = 1'b0;
    voltage_limit = VOLTAGE_LIMIT_RESET;
    current_limit = CURRENT_LIMIT_RESET;
    power_limit = POWER_LIMIT_RESET;
    error_limit = ERROR_LIMIT_RESET;
  endfunction

  function automatic void close_frame(input logic [2:0] q, input logic [1:0] st);
    result_t r;
    logic [31:0] value;
    logic [31:0] hi;
    logic [31:0] lo;
    logic good;
    hi = {16'd0, frame_payload[23:8]};
    lo = {24'd0, frame_payload[7:0]};
    good = (st == ST_OK);
    value = '0;
    r = '0;
    case (q)
      Q_VOLTAGE: begin
        if (good) value = hi * 10 + lo;
        if (!good || value == 0) begin
          if (failures_seen != COUNT_MAX) failures_seen = failures_seen + 1'b1;
        end else if (value <= voltage_limit) begin
          voltage_held = value[VOLT_W-1:0];
        end
        r.held = 24'(voltage_held);
      end
      Q_CURRENT: begin
        if (good) value = hi * 100 + lo;
        if (good && value != 0 && value <= current_limit) current_held = value[CURR_W-1:0];
        r.held = 24'(current_held);
      end
      Q_POWER: begin
        if (good) value = hi;
        if (good && value != 0 && value <= power_limit) power_held = value[POWR_W-1:0];
        r.held = 24'(power_held);
      end
      Q_ENERGY: begin
        if (good) value = {8'd0, frame_payload};
        if (good && value != 0) energy_held = frame_payload;
        r.held = energy_held;
      end
      Q_ADDRESS: begin
        if (good) begin
          link_up = 1'b1;
          failures_seen = '0;
        end
      end
      default: begin
      end
    endcase
    r.which = q;
    r.status = st;
    r.decoded = value[23:0];
    r.error_count = failures_seen;
    r.reinit_needed = (failures_seen >= error_limit);
    r.link_ready = link_up;
    expected_results.push_back(r);
    clear_frame_state();
  endfunction

  function automatic void predict_request(input logic f, input logic [2:0] q,
                                          input logic [7:0] b);
    if (f == FUNC_TIMEOUT) begin
      close_frame(q, ST_SHORT);
    end else if (frame_pos == 0) begin
      header_ok = (b == {HEADER_PREFIX, q});
      frame_sum = b;
      frame_payload = '0;
      frame_pos = 3'd1;
    end else if (frame_pos >= FRAME_BYTES - 1) begin
      if (!header_ok) close_frame(q, ST_HEADER);
      else if (b != frame_sum) close_frame(q, ST_CHECKSUM);
      else close_frame(q, ST_OK);
    end else begin
      if (frame_pos <= LAST_PAYLOAD_POS) frame_payload = {frame_payload[15:0], b};
      frame_sum = frame_sum + b;
      frame_pos = frame_pos + 1'b1;
    end
  endfunction

  function automatic logic [2:0] pick_quantity(input logic voltage_heavy);
    int roll;
    roll = $urandom_range(0, 99);
    if (!voltage_heavy) return 3'($urandom_range(Q_VOLTAGE, Q_ADDRESS));
    if (roll < 80) return Q_VOLTAGE;
    if (roll < 81) return Q_ADDRESS;
    return 3'($urandom_range(Q_CURRENT, Q_ENERGY));
  endfunction

  function automatic logic [23:0] pick_payload(input logic [2:0] q);
    logic [31:0] target;
    logic [31:0] hi;
    logic [31:0] lo;
    int scale;
    case ($urandom_range(0, 3))
      0: return '0;
      1: return 24'($urandom);
      default: begin
      end
    endcase
    case (q)
      Q_VOLTAGE: begin
        target = 32'(voltage_limit);
        scale = 10;
      end
      Q_CURRENT: begin
        target = 32'(current_limit);
        scale = 100;
      end
      Q_POWER: begin
        target = 32'(power_limit);
        scale = 1;
      end
      default: return 24'($urandom);
    endcase
    target = target + $urandom_range(0, 2);
    if (target > 0) target = target - 1;
    if (scale == 1) begin
      hi = target;
      lo = $urandom_range(0, 255);
    end else begin
      hi = target / scale;
      lo = target % scale;
    end
    if (hi > 32'hFFFF) begin
      hi = 32'hFFFF;
      lo = 32'hFF;
    end
    return {hi[15:0], lo[7:0]};
  endfunction

  task automatic send_request(input logic f, input logic [2:0] q, input logic [7:0] b);
    int gap;
    gap = sender_steady ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    quantity <= q;
    rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(f, q, b);
    requests_sent++;
  endtask

  task automatic send_frame(input logic [2:0] q, input logic [2:0] last_q,
                            input logic [23:0] data, input frame_flaw_t flaw,
                            input int cut_len);
    logic [7:0] bytes [FRAME_BYTES];
    logic [7:0] sum;
    logic [2:0] item_q;
    int count;
    if (frame_pos != 0) send_request(FUNC_TIMEOUT, q, 8'($urandom));
    bytes[0] = {HEADER_PREFIX, q};
    if (flaw == FLAW_HEADER || flaw == FLAW_BOTH) begin
      bytes[0] = bytes[0] ^ 8'($urandom_range(1, 255));
    end
    bytes[1] = data[23:16];
    bytes[2] = data[15:8];
    bytes[3] = data[7:0];
    bytes[4] = 8'($urandom);
    bytes[5] = 8'($urandom);
    sum = '0;
    for (int i = 0; i < FRAME_BYTES - 1; i++) sum = sum + bytes[i];
    bytes[FRAME_BYTES-1] = sum;
    if (flaw == FLAW_CHECKSUM || flaw == FLAW_BOTH) begin
      bytes[FRAME_BYTES-1] = sum ^ 8'($urandom_range(1, 255));
    end
    count = (flaw == FLAW_CUT) ? cut_len : FRAME_BYTES;
    for (int i = 0; i < count; i++) begin
      if (i == 0) item_q = q;
      else if (i == FRAME_BYTES - 1) item_q = last_q;
      else item_q = 3'($urandom_range(Q_VOLTAGE, Q_ADDRESS));
      send_request(FUNC_BYTE, item_q, bytes[i]);
    end
    if (flaw == FLAW_CUT) send_request(FUNC_TIMEOUT, last_q, 8'($urandom));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_limits(input logic [VOLT_W-1:0] v, input logic [CURR_W-1:0] c,
                             input logic [POWR_W-1:0] p, input logic [CNT_W-1:0] e);
    logic [CFG_INDEX_W-1:0] regs [4];
    logic [CFG_DATA_W-1:0] values [4];
    regs[0] = REG_VOLTAGE_LIMIT;
    regs[1] = REG_CURRENT_LIMIT;
    regs[2] = REG_POWER_LIMIT;
    regs[3] = REG_ERROR_LIMIT;
    values[0] = CFG_DATA_W'(v);
    values[1] = c;
    values[2] = CFG_DATA_W'(p);
    values[3] = CFG_DATA_W'(e);
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= values[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    voltage_limit = v;
    current_limit = c;
    power_limit = p;
    error_limit = e;
  endtask

  task automatic test_directed();
    sender_steady = 1'b0;
    receiver_steady = 1'b0;
    send_frame(Q_VOLTAGE, Q_VOLTAGE, {16'd400, 8'd0}, FLAW_NONE, 0);
    send_request(FUNC_TIMEOUT, Q_ENERGY, 8'hFF);
    send_frame(Q_CURRENT, Q_POWER, 24'h123456, FLAW_CUT, 2);
    send_frame(Q_POWER, Q_POWER, 24'h000000, FLAW_BOTH, 0);
    send_frame(Q_ADDRESS, Q_ADDRESS, 24'hFFFFFF, FLAW_NONE, 0);
    wait_drained();
  endtask

  task automatic test_random_mix(input int quota, input logic voltage_heavy,
                                 input logic steady);
    int stop_at;
    int roll;
    int flaw_share;
    logic [2:0] q;
    logic [2:0] last_q;
    frame_flaw_t flaw;
    stop_at = requests_sent + quota;
    sender_steady = steady;
    receiver_steady = steady;
    flaw_share = voltage_heavy ? 50 : 30;
    while (requests_sent < stop_at) begin
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
        send_request(1'($urandom), 3'($urandom_range(Q_VOLTAGE, Q_ADDRESS)), 8'($urandom));
      end else begin
        q = pick_quantity(voltage_heavy);
        last_q = q;
        if ($urandom_range(0, 9) == 0) last_q = 3'($urandom_range(Q_VOLTAGE, Q_ADDRESS));
        roll = $urandom_range(0, 99);
        if (roll >= flaw_share) flaw = FLAW_NONE;
        else if (roll < flaw_share / 4) flaw = FLAW_HEADER;
        else if (roll < flaw_share / 2) flaw = FLAW_CHECKSUM;
        else if (roll < flaw_share * 3 / 4) flaw = FLAW_BOTH;
        else flaw = FLAW_CUT;
        send_frame(q, last_q, pick_payload(q), flaw, $urandom_range(0, FRAME_BYTES - 1));
      end
    end
    wait_drained();
  endtask

  task automatic test_receiver_hold();
    sender_steady = 1'b1;
    receiver_steady = 1'b0;
    receiver_hold = 300;
    repeat (24) begin
      send_request(FUNC_TIMEOUT, 3'($urandom_range(Q_VOLTAGE, Q_ADDRESS)), 8'($urandom));
    end
    repeat (3) send_frame(Q_ENERGY, Q_ENERGY, 24'($urandom), FLAW_NONE, 0);
    wait_drained();
  endtask

  task automatic test_sender_pause();
    logic [2:0] q;
    sender_steady = 1'b0;
    receiver_steady = 1'b0;
    repeat (3) begin
      q = pick_quantity(1'b0);
      send_frame(q, q, pick_payload(q), FLAW_NONE, 0);
      send_request(FUNC_TIMEOUT, Q_VOLTAGE, 8'($urandom));
      wait_drained();
    end
  endtask

  task automatic check_result();
    result_t seen;
    result_t want;
    seen = {which, status, decoded, held, error_count, reinit_needed, link_ready};
    if (expected_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("%0t: result with no request pending: which %0d status %0d decoded %0d",
                 $realtime, seen.which, seen.status, seen.decoded);
      end
    end else begin
      want = expected_results.pop_front();
      if (seen !== want) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: mismatch (expected/actual) which %0d/%0d status %0d/%0d",
                   $realtime, want.which, seen.which, want.status, seen.status);
          $display("  decoded %0d/%0d held %0d/%0d count %0d/%0d reinit %0b/%0b link %0b/%0b",
                   want.decoded, seen.decoded, want.held, seen.held,
                   want.error_count, seen.error_count, want.reinit_needed,
                   seen.reinit_needed, want.link_ready, seen.link_ready);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_result();
  end

  initial begin
    int stall;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (receiver_hold > 0) stall = receiver_hold;
      else if (receiver_steady) stall = 0;
      else stall = $urandom_range(0, 15);
      receiver_hold = 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    #5_000_000;
    $display("meter_response_frame_decoder_test: done, errors");
    $finish;
  end

  initial begin
    reset_meter_model();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    load_limits(VOLTAGE_LIMIT_RESET, CURRENT_LIMIT_RESET, POWER_LIMIT_RESET,
                ERROR_LIMIT_RESET);
    test_random_mix(180, 1'b0, 1'b0);
    load_limits(20'd655605, 23'd6553755, 16'hFFFF, 5'd31);
    test_random_mix(180, 1'b1, 1'b1);
    test_receiver_hold();
    load_limits('0, '0, '0, 5'd1);
    test_random_mix(150, 1'b0, 1'b0);
    test_sender_pause();
    load_limits(20'($urandom_range(0, 655605)), 23'($urandom_range(0, 6553755)),
                16'($urandom), 5'($urandom_range(1, 31)));
    test_random_mix(180, 1'b1, 1'b0);
    load_limits(20'($urandom_range(0, 2000)), 23'($urandom_range(0, 20000)),
                16'($urandom_range(0, 500)), 5'($urandom_range(1, 8)));
    test_random_mix(180, 1'b0, 1'b0);
    for (int n = 0; n < 4000 && expected_results.size() != 0; n++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0d expected results never arrived", expected_results.size());
    end
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("meter_response_frame_decoder_test: done, clean");
    end else begin
      $display("meter_response_frame_decoder_test: done, errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/mrfd_pkg.sv
src/meter_response_frame_decoder.sv
bench/meter_response_frame_decoder_test.sv
